FILE: hw/rtl/rx_descriptor_ring_scanner_top_defines.svh
// Assertion helpers used by the datapath RTL file of the descriptor ring scanner.
// Both expect the module to have i_clk and i_rst_n in scope.
`ifndef RX_DESCRIPTOR_RING_SCANNER_TOP_DEFINES_SVH
`define RX_DESCRIPTOR_RING_SCANNER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rdrs_pkg.sv
package rdrs_pkg;

    localparam int RING_DEPTH_DEF   = 16;
    localparam int BUFFER_BYTES_DEF = 128;
    localparam int FCS_BYTES        = 4;

    localparam int LEN_W   = 13;
    localparam int SLOT_W  = 4;
    localparam int CHUNK_W = 8;

    // Operation codes carried on the input channel.
    localparam logic OP_FILL  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic fill;
        logic fetch_init;
        logic guard_clr;
        logic guard_inc;
        logic release_slot;
        logic walk_init;
        logic walk_take;
        logic walk_adv;
        logic nbuf_dec;
        logic attempt_inc;
        logic calc;
        logic emit;
        logic emit_empty;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip_cond;
        logic owned_rp;
        logic guard_done;
        logic step_done;
        logic step_zero;
        logic owned_idx;
        logic start_idx;
        logic end_idx;
        logic nbuf_zero;
        logic attempt_last;
        logic frame_ok;
        logic chunk_last;
        logic out_free;
    } t_status;

endpackage

FILE: hw/rtl/rdrs_ctrl.sv
module rdrs_ctrl
    import rdrs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_op,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SKIP  = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;
    localparam logic [2:0] ST_DROP  = 3'd6;
    localparam logic [2:0] ST_EMPTY = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_op == OP_FILL) begin
                        o_cmd.fill = 1'b1;
                    end else begin
                        o_cmd.fetch_init = 1'b1;
                        n_state          = ST_SKIP;
                    end
                end
            end
            ST_SKIP: begin
                // Release owned slots that do not open a frame.
                if (!i_status.guard_done && i_status.skip_cond) begin
                    o_cmd.release_slot = 1'b1;
                    o_cmd.guard_inc    = 1'b1;
                end else if (!i_status.owned_rp) begin
                    n_state = ST_EMPTY;
                end else begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_status.step_done) begin
                    n_state = ST_DROP;
                end else if (!i_status.owned_idx) begin
                    n_state = ST_EMPTY;
                end else if (!i_status.step_zero && i_status.start_idx) begin
                    n_state = ST_DROP;
                end else begin
                    o_cmd.walk_take = 1'b1;
                    if (i_status.end_idx) begin
                        n_state = ST_LEN;
                    end else begin
                        o_cmd.walk_adv = 1'b1;
                    end
                end
            end
            ST_LEN: begin
                if (i_status.frame_ok) begin
                    o_cmd.calc = 1'b1;
                    n_state    = ST_EMIT;
                end else begin
                    n_state = ST_DROP;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit         = 1'b1;
                    o_cmd.release_slot = 1'b1;
                    o_cmd.nbuf_dec     = 1'b1;
                    if (i_status.chunk_last) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_status.nbuf_zero) begin
                    o_cmd.release_slot = 1'b1;
                    o_cmd.nbuf_dec     = 1'b1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DROP: begin
                if (!i_status.nbuf_zero) begin
                    o_cmd.release_slot = 1'b1;
                    o_cmd.nbuf_dec     = 1'b1;
                end else if (i_status.attempt_last) begin
                    n_state = ST_EMPTY;
                end else begin
                    o_cmd.attempt_inc = 1'b1;
                    o_cmd.guard_clr   = 1'b1;
                    n_state           = ST_SKIP;
                end
            end
            ST_EMPTY: begin
                if (i_status.out_free) begin
                    o_cmd.emit_empty = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/rdrs_datapath.sv
`include "rx_descriptor_ring_scanner_top_defines.svh"

module rdrs_datapath
    import rdrs_pkg::*;
#(
    parameter int RING_DEPTH   = RING_DEPTH_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [SLOT_W-1:0]  i_desc_index,
    input  logic               i_start_mark,
    input  logic               i_end_mark,
    input  logic [LEN_W-1:0]   i_wire_length,
    input  logic [LEN_W-1:0]   i_max_length,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_found,
    output logic [LEN_W-1:0]   o_payload_bytes,
    output logic [SLOT_W-1:0]  o_chunk_slot,
    output logic [CHUNK_W-1:0] o_chunk_bytes,
    output logic               o_last
);

    localparam int IW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW   = $clog2(RING_DEPTH + 1);
    localparam int BW   = $clog2(BUFFER_BYTES + 1);
    localparam int CAPW = CW + BW;
    localparam int TW   = (CAPW > LEN_W) ? CAPW : LEN_W;

    localparam logic [IW-1:0]    LAST_SLOT = IW'(RING_DEPTH - 1);
    localparam logic [CW-1:0]    DEPTH_CNT = CW'(RING_DEPTH);
    localparam logic [TW-1:0]    BUF_T     = TW'(BUFFER_BYTES);
    localparam logic [LEN_W-1:0] FCS_L     = LEN_W'(FCS_BYTES);

    logic [RING_DEPTH-1:0] r_owned;
    logic [RING_DEPTH-1:0] r_start;
    logic [RING_DEPTH-1:0] r_end;
    logic [LEN_W-1:0]      r_len_mem [RING_DEPTH];
    logic [LEN_W-1:0]      r_len_q;

    logic [IW-1:0]    r_rp;
    logic [IW-1:0]    r_idx;
    logic [CW-1:0]    r_guard;
    logic [CW-1:0]    r_step;
    logic [CW-1:0]    r_nbuf;
    logic [IW-1:0]    r_attempt;
    logic [LEN_W-1:0] r_max_len;
    logic [LEN_W-1:0] r_total;
    logic [LEN_W-1:0] r_left;

    logic               r_out_valid;
    logic               r_found;
    logic [LEN_W-1:0]   r_payload;
    logic [SLOT_W-1:0]  r_slot;
    logic [CHUNK_W-1:0] r_chunk;
    logic               r_last;

    logic             fill_hit;
    logic [IW-1:0]    fill_addr;
    logic [IW-1:0]    n_rp;
    logic [IW-1:0]    n_idx;
    logic [LEN_W-1:0] net_len;
    logic [TW-1:0]    cap;
    logic [LEN_W-1:0] total;
    logic [LEN_W-1:0] chunk;
    logic             chunk_last;
    logic             out_free;

    assign fill_hit  = 32'(i_desc_index) < RING_DEPTH;
    assign fill_addr = IW'(i_desc_index);
    assign n_rp      = (r_rp == LAST_SLOT) ? '0 : r_rp + 1'b1;
    assign n_idx     = (r_idx == LAST_SLOT) ? '0 : r_idx + 1'b1;

    // Payload after the FCS is stripped, and the part of it the run's buffers can hold.
    assign net_len    = (r_len_q > FCS_L) ? r_len_q - FCS_L : '0;
    assign cap        = TW'(r_nbuf) * BUF_T;
    assign total      = (TW'(net_len) < cap) ? net_len : LEN_W'(cap);
    assign chunk_last = TW'(r_left) <= BUF_T;
    assign chunk      = chunk_last ? r_left : LEN_W'(BUF_T);
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        o_status              = '0;
        o_status.skip_cond    = r_owned[r_rp] && !r_start[r_rp];
        o_status.owned_rp     = r_owned[r_rp];
        o_status.guard_done   = r_guard == DEPTH_CNT;
        o_status.step_done    = r_step == DEPTH_CNT;
        o_status.step_zero    = r_step == '0;
        o_status.owned_idx    = r_owned[r_idx];
        o_status.start_idx    = r_start[r_idx];
        o_status.end_idx      = r_end[r_idx];
        o_status.nbuf_zero    = r_nbuf == '0;
        o_status.attempt_last = r_attempt == LAST_SLOT;
        o_status.frame_ok     = (net_len != '0) && (net_len <= r_max_len);
        o_status.chunk_last   = chunk_last;
        o_status.out_free     = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owned <= '0;
            r_start <= '0;
            r_end   <= '0;
            r_rp    <= '0;
        end else begin
            if (i_cmd.fill && fill_hit) begin
                r_owned[fill_addr] <= 1'b1;
                r_start[fill_addr] <= i_start_mark;
                r_end[fill_addr]   <= i_end_mark;
            end
            if (i_cmd.release_slot) begin
                r_owned[r_rp] <= 1'b0;
                r_rp          <= n_rp;
            end
        end
    end

    // Length store: written by fills, read at the walk index with a registered output.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill && fill_hit) begin
            r_len_mem[fill_addr] <= i_wire_length;
        end
        r_len_q <= r_len_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_guard   <= '0;
            r_step    <= '0;
            r_nbuf    <= '0;
            r_attempt <= '0;
        end else begin
            if (i_cmd.fetch_init || i_cmd.guard_clr) begin
                r_guard <= '0;
            end else if (i_cmd.guard_inc) begin
                r_guard <= r_guard + 1'b1;
            end
            if (i_cmd.fetch_init) begin
                r_attempt <= '0;
            end else if (i_cmd.attempt_inc) begin
                r_attempt <= r_attempt + 1'b1;
            end
            if (i_cmd.walk_init) begin
                r_idx  <= r_rp;
                r_step <= '0;
            end else if (i_cmd.walk_adv) begin
                r_idx  <= n_idx;
                r_step <= r_step + 1'b1;
            end
            if (i_cmd.walk_init) begin
                r_nbuf <= '0;
            end else if (i_cmd.walk_take) begin
                r_nbuf <= r_nbuf + 1'b1;
            end else if (i_cmd.nbuf_dec) begin
                r_nbuf <= r_nbuf - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch_init) begin
            r_max_len <= i_max_length;
        end
        if (i_cmd.calc) begin
            r_total <= total;
            r_left  <= total;
        end else if (i_cmd.emit) begin
            r_left <= r_left - chunk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_empty) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_found   <= 1'b1;
            r_payload <= r_total;
            r_slot    <= SLOT_W'(r_rp);
            r_chunk   <= CHUNK_W'(chunk);
            r_last    <= chunk_last;
        end else if (i_cmd.emit_empty) begin
            r_found   <= 1'b0;
            r_payload <= '0;
            r_slot    <= '0;
            r_chunk   <= '0;
            r_last    <= 1'b1;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_payload_bytes = r_payload;
    assign o_chunk_slot    = r_slot;
    assign o_chunk_bytes   = r_chunk;
    assign o_last          = r_last;

    `RDRS_ASSERT_NOW(a_rp_range, 1'b1, r_rp <= LAST_SLOT, "read pointer left the ring")
    `RDRS_ASSERT_NOW(a_nbuf_range, 1'b1, r_nbuf <= DEPTH_CNT, "run count exceeds ring depth")
    `RDRS_ASSERT_NOW(a_load_free, i_cmd.emit || i_cmd.emit_empty, out_free,
                     "result loaded over a pending result")
    `RDRS_ASSERT_NOW(a_emit_owned, i_cmd.emit, r_owned[r_rp] && r_nbuf != '0,
                     "chunk emitted from a slot outside the run")
    `RDRS_ASSERT_NEXT(a_release_clears, i_cmd.release_slot, !r_owned[$past(r_rp)],
                      "released slot still owned")

endmodule

FILE: hw/rtl/rx_descriptor_ring_scanner_top.sv
// Receive descriptor ring scanner.
// Input channel (i_in_valid / o_in_ready) carries one transaction per item. With i_op low
// the item records one descriptor written by the DMA and gives no result.
// With i_op high the item fetches the next frame from the read pointer and gives one result
// per buffer chunk (found set, last on the final chunk), or one empty result with last set.
// Results leave on the output channel (o_out_valid / i_out_ready) from an output register.
// A new input is accepted only after the previous fetch has loaded its last result; that
// result may still wait in the output register while the next item is taken.
// A fetch is run by the scan sequencer: it releases skipped slots, walks the run to its end
// mark, looks up the length, emits each chunk while releasing its slot, and then releases the
// rest of the run; a failed attempt releases its run and starts again. Every attempt releases at
// least one slot and nothing refills the ring during a fetch, so a fetch always ends.
// When the receiver stalls, the sequencer holds on the pending chunk until the output
// register frees. Reset clears all ownership and mark flags and the read pointer; stored
// lengths are only read from owned slots and need no clearing.
module rx_descriptor_ring_scanner_top
    import rdrs_pkg::*;
#(
    parameter int RING_DEPTH   = RING_DEPTH_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_op,
    input  logic [SLOT_W-1:0]  i_desc_index,
    input  logic               i_start_mark,
    input  logic               i_end_mark,
    input  logic [LEN_W-1:0]   i_wire_length,
    input  logic [LEN_W-1:0]   i_max_length,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_found,
    output logic [LEN_W-1:0]   o_payload_bytes,
    output logic [SLOT_W-1:0]  o_chunk_slot,
    output logic [CHUNK_W-1:0] o_chunk_bytes,
    output logic               o_last
);

    t_cmd    cmd;
    t_status status;

    rdrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    rdrs_datapath #(
        .RING_DEPTH   (RING_DEPTH),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_desc_index    (i_desc_index),
        .i_start_mark    (i_start_mark),
        .i_end_mark      (i_end_mark),
        .i_wire_length   (i_wire_length),
        .i_max_length    (i_max_length),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_found         (o_found),
        .o_payload_bytes (o_payload_bytes),
        .o_chunk_slot    (o_chunk_slot),
        .o_chunk_bytes   (o_chunk_bytes),
        .o_last          (o_last)
    );

endmodule
